// ===== sv/dsrp_pkg.sv =====
package dsrp_pkg;

  // default ramp length and the fixed acceleration table
  localparam int RAMP_DEPTH_DEF = 400;
  localparam int TABLE_SIZE     = 400;
  localparam int TABLE_AW       = 9;
  localparam int ENTRY_W        = 15;
  localparam int FACTOR_W       = 15;
  localparam int PERIOD_W       = 22;
  localparam int STEPS_W        = 16;
  localparam int FRAC_W         = 8;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_MOVE       = 2'd1,
    CMD_SOFT_STOP  = 2'd2,
    CMD_FORCE_STOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_MOVE  = 2'd1,
    MODE_DECEL = 2'd2
  } mode_t;

  // bit0 left, bit1 right: left idles high, right idles low
  localparam logic [1:0] DIR_IDLE = 2'b01;

  typedef struct packed {
    logic left_clk;
    logic right_clk;
    logic left_dir_pin;
    logic right_dir_pin;
    logic busy;
    logic accepted;
  } res_t;

  localparam logic [ENTRY_W-1:0] RAMP_TABLE [TABLE_SIZE] = '{
    15'd31953,15'd13235,15'd10155,15'd8561,15'd7543,15'd6819,15'd6271,15'd5837,15'd5482,15'd5185,
    15'd4931,15'd4712,15'd4519,15'd4349,15'd4196,15'd4058,15'd3933,15'd3819,15'd3714,15'd3618,
    15'd3528,15'd3445,15'd3368,15'd3295,15'd3227,15'd3164,15'd3103,15'd3046,15'd2992,15'd2941,
    15'd2893,15'd2846,15'd2802,15'd2760,15'd2720,15'd2681,15'd2644,15'd2609,15'd2574,15'd2542,
    15'd2510,15'd2480,15'd2450,15'd2422,15'd2395,15'd2368,15'd2342,15'd2318,15'd2294,15'd2270,
    15'd2248,15'd2226,15'd2205,15'd2184,15'd2164,15'd2144,15'd2125,15'd2106,15'd2088,15'd2071,
    15'd2054,15'd2037,15'd2020,15'd2004,15'd1989,15'd1974,15'd1959,15'd1944,15'd1930,15'd1916,
    15'd1902,15'd1889,15'd1876,15'd1863,15'd1851,15'd1838,15'd1826,15'd1814,15'd1803,15'd1791,
    15'd1780,15'd1769,15'd1758,15'd1748,15'd1738,15'd1727,15'd1717,15'd1707,15'd1698,15'd1688,
    15'd1679,15'd1670,15'd1661,15'd1652,15'd1643,15'd1634,15'd1626,15'd1618,15'd1609,15'd1601,
    15'd1593,15'd1585,15'd1578,15'd1570,15'd1562,15'd1555,15'd1548,15'd1540,15'd1533,15'd1526,
    15'd1519,15'd1513,15'd1506,15'd1499,15'd1493,15'd1486,15'd1480,15'd1473,15'd1467,15'd1461,
    15'd1455,15'd1449,15'd1443,15'd1437,15'd1431,15'd1426,15'd1420,15'd1414,15'd1409,15'd1403,
    15'd1398,15'd1393,15'd1387,15'd1382,15'd1377,15'd1372,15'd1367,15'd1362,15'd1357,15'd1352,
    15'd1347,15'd1343,15'd1338,15'd1333,15'd1329,15'd1324,15'd1319,15'd1315,15'd1311,15'd1306,
    15'd1302,15'd1298,15'd1293,15'd1289,15'd1285,15'd1281,15'd1277,15'd1273,15'd1269,15'd1265,
    15'd1261,15'd1257,15'd1253,15'd1249,15'd1245,15'd1241,15'd1238,15'd1234,15'd1230,15'd1227,
    15'd1223,15'd1219,15'd1216,15'd1212,15'd1209,15'd1206,15'd1202,15'd1199,15'd1195,15'd1192,
    15'd1189,15'd1185,15'd1182,15'd1179,15'd1176,15'd1173,15'd1169,15'd1166,15'd1163,15'd1160,
    15'd1157,15'd1154,15'd1151,15'd1148,15'd1145,15'd1142,15'd1139,15'd1136,15'd1133,15'd1131,
    15'd1128,15'd1125,15'd1122,15'd1119,15'd1117,15'd1114,15'd1111,15'd1109,15'd1106,15'd1103,
    15'd1101,15'd1098,15'd1095,15'd1093,15'd1090,15'd1088,15'd1085,15'd1083,15'd1080,15'd1078,
    15'd1075,15'd1073,15'd1071,15'd1068,15'd1066,15'd1063,15'd1061,15'd1059,15'd1056,15'd1054,
    15'd1052,15'd1050,15'd1047,15'd1045,15'd1043,15'd1041,15'd1038,15'd1036,15'd1034,15'd1032,
    15'd1030,15'd1028,15'd1025,15'd1023,15'd1021,15'd1019,15'd1017,15'd1015,15'd1013,15'd1011,
    15'd1009,15'd1007,15'd1005,15'd1003,15'd1001,15'd999,15'd997,15'd995,15'd993,15'd991,
    15'd989,15'd987,15'd986,15'd984,15'd982,15'd980,15'd978,15'd976,15'd975,15'd973,
    15'd971,15'd969,15'd967,15'd966,15'd964,15'd962,15'd960,15'd959,15'd957,15'd955,
    15'd953,15'd952,15'd950,15'd948,15'd947,15'd945,15'd943,15'd942,15'd940,15'd938,
    15'd937,15'd935,15'd934,15'd932,15'd930,15'd929,15'd927,15'd926,15'd924,15'd923,
    15'd921,15'd920,15'd918,15'd917,15'd915,15'd914,15'd912,15'd911,15'd909,15'd908,
    15'd906,15'd905,15'd903,15'd902,15'd900,15'd899,15'd898,15'd896,15'd895,15'd893,
    15'd892,15'd891,15'd889,15'd888,15'd886,15'd885,15'd884,15'd882,15'd881,15'd880,
    15'd878,15'd877,15'd876,15'd874,15'd873,15'd872,15'd870,15'd869,15'd868,15'd867,
    15'd865,15'd864,15'd863,15'd862,15'd860,15'd859,15'd858,15'd857,15'd855,15'd854,
    15'd853,15'd852,15'd850,15'd849,15'd848,15'd847,15'd846,15'd844,15'd843,15'd842,
    15'd841,15'd840,15'd839,15'd837,15'd836,15'd835,15'd834,15'd833,15'd832,15'd831,
    15'd830,15'd828,15'd827,15'd826,15'd825,15'd824,15'd823,15'd822,15'd821,15'd820,
    15'd819,15'd817,15'd816,15'd815,15'd814,15'd813,15'd812,15'd811,15'd810,15'd809,
    15'd808,15'd807,15'd806,15'd805,15'd804,15'd803,15'd802,15'd801,15'd800,15'd799
  };

endpackage

// ===== sv/dsrp_period.sv =====
module dsrp_period #(
  parameter int RAMP_DEPTH = dsrp_pkg::RAMP_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dsrp_pkg::FACTOR_W-1:0]       cfg_data,
  input  logic                                rd_en,
  input  logic [$clog2(RAMP_DEPTH)-1:0]       rd_idx,
  output logic [dsrp_pkg::PERIOD_W-1:0]       period
);
  import dsrp_pkg::*;

  localparam int IW   = $clog2(RAMP_DEPTH);
  localparam int XW   = (IW > TABLE_AW) ? IW : TABLE_AW;
  localparam int PW   = ENTRY_W + FACTOR_W;

  logic [FACTOR_W-1:0] slow_factor;
  logic [XW-1:0]       idx_wide;
  logic [TABLE_AW-1:0] rom_addr;
  logic [ENTRY_W-1:0]  rom_data;
  logic [ENTRY_W-1:0]  entry_d;
  logic [PW-1:0]       prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_factor <= '0;
    end else if (cfg_we) begin
      slow_factor <= cfg_data;
    end
  end

  // indexes past the table end read the last entry
  assign idx_wide = XW'(rd_idx);
  assign rom_addr = (idx_wide >= XW'(TABLE_SIZE - 1)) ? TABLE_AW'(TABLE_SIZE - 1)
                                                      : idx_wide[TABLE_AW-1:0];

  // synchronous table read, held until the next step start
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rom_data <= RAMP_TABLE[rom_addr];
    end
  end

  always_ff @(posedge clk) begin
    prod    <= PW'(rom_data) * PW'(slow_factor);
    entry_d <= rom_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= '0;
    end else begin
      period <= PERIOD_W'(entry_d) + PERIOD_W'(prod[PW-1:FRAC_W]);
    end
  end

endmodule

// ===== sv/dsrp_ctrl.sv =====
module dsrp_ctrl #(
  parameter int RAMP_DEPTH = dsrp_pkg::RAMP_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  dsrp_pkg::cmd_t                  cmd,
  input  logic                            left_forward,
  input  logic                            right_forward,
  input  logic                            left_half,
  input  logic                            right_half,
  input  logic [dsrp_pkg::STEPS_W-1:0]    step_count,
  input  logic [dsrp_pkg::PERIOD_W-1:0]   period,
  output logic                            rd_en,
  output logic [$clog2(RAMP_DEPTH)-1:0]   rd_idx,
  output dsrp_pkg::res_t                  res
);
  import dsrp_pkg::*;

  localparam int CW = $clog2(RAMP_DEPTH + 1);
  localparam int IW = $clog2(RAMP_DEPTH);

  mode_t               mode, mode_next;
  logic [CW-1:0]       ramp_count, ramp_count_next;
  logic [STEPS_W-1:0]  steps_left, steps_left_next;
  logic                step_odd, step_odd_next;
  logic [PERIOD_W-1:0] elapsed, elapsed_next;
  logic                clock_high, clock_high_next;
  logic [1:0]          half_flags, half_flags_next;
  logic [1:0]          dir_pins, dir_pins_next;
  logic [1:0]          pulse_mask, pulse_mask_next;

  logic [CW-1:0]       count_dec;
  logic [IW-1:0]       idx_move, idx_dec;
  logic [PERIOD_W-1:0] elapsed_inc;

  assign count_dec   = ramp_count - CW'(1);
  assign idx_move    = (ramp_count >= CW'(RAMP_DEPTH - 1)) ? IW'(RAMP_DEPTH - 1)
                                                           : ramp_count[IW-1:0];
  assign idx_dec     = (count_dec >= CW'(RAMP_DEPTH - 1)) ? IW'(RAMP_DEPTH - 1)
                                                          : count_dec[IW-1:0];
  assign elapsed_inc = elapsed + PERIOD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      ramp_count <= '0;
      steps_left <= '0;
      step_odd   <= 1'b0;
      elapsed    <= '0;
      clock_high <= 1'b0;
      half_flags <= '0;
      dir_pins   <= DIR_IDLE;
      pulse_mask <= '0;
    end else begin
      mode       <= mode_next;
      ramp_count <= ramp_count_next;
      steps_left <= steps_left_next;
      step_odd   <= step_odd_next;
      elapsed    <= elapsed_next;
      clock_high <= clock_high_next;
      half_flags <= half_flags_next;
      dir_pins   <= dir_pins_next;
      pulse_mask <= pulse_mask_next;
    end
  end

  always_comb begin
    logic               step_go;
    logic               parity;
    logic               odd_src;
    logic [STEPS_W-1:0] steps_src;
    logic [1:0]         half_src;
    logic               accepted;

    mode_next       = mode;
    ramp_count_next = ramp_count;
    steps_left_next = steps_left;
    step_odd_next   = step_odd;
    elapsed_next    = elapsed;
    clock_high_next = clock_high;
    half_flags_next = half_flags;
    dir_pins_next   = dir_pins;
    pulse_mask_next = pulse_mask;
    step_go         = 1'b0;
    parity          = 1'b0;
    odd_src         = step_odd;
    steps_src       = steps_left;
    half_src        = half_flags;
    accepted        = 1'b0;
    rd_idx          = idx_move;

    if (go) begin
      case (cmd)
        CMD_TICK: begin
          if (mode != MODE_IDLE) begin
            if (clock_high) begin
              elapsed_next = elapsed_inc;
              if (elapsed_inc == period) begin
                clock_high_next = 1'b0;
              end
            end else if (mode == MODE_MOVE) begin
              if (steps_left != '0) begin
                step_go = 1'b1;
              end else begin
                mode_next       = MODE_IDLE;
                clock_high_next = 1'b0;
              end
            end else begin
              if (ramp_count != '0) begin
                step_go = 1'b1;
              end else begin
                mode_next       = MODE_IDLE;
                clock_high_next = 1'b0;
                dir_pins_next   = DIR_IDLE;
              end
            end
          end
        end
        CMD_MOVE: begin
          if (mode == MODE_IDLE) begin
            accepted        = 1'b1;
            dir_pins_next   = {~right_forward, left_forward};
            half_flags_next = {right_half, left_half};
            half_src        = {right_half, left_half};
            steps_left_next = step_count;
            steps_src       = step_count;
            step_odd_next   = 1'b0;
            odd_src         = 1'b0;
            if (step_count != '0) begin
              mode_next = MODE_MOVE;
              step_go   = 1'b1;
            end
          end
        end
        CMD_SOFT_STOP: begin
          if (mode == MODE_IDLE && ramp_count != '0) begin
            accepted  = 1'b1;
            mode_next = MODE_DECEL;
            step_go   = 1'b1;
          end
        end
        CMD_FORCE_STOP: begin
          if (mode != MODE_IDLE || ramp_count != '0) begin
            accepted        = 1'b1;
            ramp_count_next = '0;
            steps_left_next = '0;
            mode_next       = MODE_IDLE;
            clock_high_next = 1'b0;
            elapsed_next    = '0;
            dir_pins_next   = DIR_IDLE;
          end
        end
        default: begin
          accepted = 1'b0;
        end
      endcase
    end

    // start of a step: table read issued here, period follows through the table, product and sum registers
    if (step_go) begin
      if (mode_next == MODE_MOVE) begin
        parity          = odd_src;
        rd_idx          = idx_move;
        ramp_count_next = CW'(idx_move) + CW'(1);
        step_odd_next   = ~odd_src;
        steps_left_next = steps_src - STEPS_W'(1);
      end else begin
        parity          = ramp_count[0];
        rd_idx          = idx_dec;
        ramp_count_next = count_dec;
      end
      pulse_mask_next = {~half_src[1] | parity, ~half_src[0] | parity};
      clock_high_next = 1'b1;
      elapsed_next    = '0;
    end

    rd_en             = step_go;
    res.left_clk      = clock_high_next & pulse_mask_next[0];
    res.right_clk     = clock_high_next & pulse_mask_next[1];
    res.left_dir_pin  = dir_pins_next[0];
    res.right_dir_pin = dir_pins_next[1];
    res.busy          = (mode_next != MODE_IDLE);
    res.accepted      = accepted;
  end

endmodule

// ===== sv/dsrp_skid.sv =====
module dsrp_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dsrp_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output dsrp_pkg::res_t out_data
);
  import dsrp_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic out_free;

  assign out_free = ~out_valid | ~out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_free) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// ===== sv/dual_stepper_ramp_pulser.sv =====
// step / direction / enable generator for two stepper motors
//
// input channel (in_valid / in_stall) carries one command item: a
// microsecond tick, a move start, a soft stop or a force stop, with the move's
// directions, half-rate flags and step count. every accepted item gives
// exactly one result item on the output channel (out_valid / out_stall):
// both clock pin levels, both dir pins, enable, busy and the accepted flag.
// the result is registered into the output stage, or the skid when the output
// is held, and a new item can be taken every cycle while the skid is free. the
// step period comes from a synchronous ramp table followed by a registered
// multiply and add; steps are far longer than that path.
// a two-entry output stage (output register plus skid) lets the block take
// one more item while a result waits; with both full, in_stall rises until
// the receiver takes a result.
// reset (rst, synchronous) gives idle mode, ramp counter zero, clocks low,
// dir pins left high / right low, slow factor zero and an empty output.
// cfg_we / cfg_data writes the q7.8 slow factor; write it only while idle
module dual_stepper_ramp_pulser #(
  parameter int RAMP_DEPTH = dsrp_pkg::RAMP_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dsrp_pkg::FACTOR_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        cmd,
  input  logic                              left_forward,
  input  logic                              right_forward,
  input  logic                              left_half,
  input  logic                              right_half,
  input  logic [dsrp_pkg::STEPS_W-1:0]      step_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              left_clk,
  output logic                              right_clk,
  output logic                              left_dir_pin,
  output logic                              right_dir_pin,
  output logic                              enable_pin,
  output logic                              busy_res,
  output logic                              accepted
);
  import dsrp_pkg::*;

  logic                          in_go;
  logic                          skid_full;
  logic                          rd_en;
  logic [$clog2(RAMP_DEPTH)-1:0] rd_idx;
  logic [PERIOD_W-1:0]           period;
  res_t                          res;
  res_t                          out_res;

  // item taken whenever the skid entry is free
  assign in_stall = skid_full;
  assign in_go    = in_valid & ~in_stall;

  // ramp table and period scaling
  dsrp_period #(
    .RAMP_DEPTH (RAMP_DEPTH)
  ) u_period (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .period   (period)
  );

  // move / deceleration sequencing and step timing
  dsrp_ctrl #(
    .RAMP_DEPTH (RAMP_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .go            (in_go),
    .cmd           (cmd_t'(cmd)),
    .left_forward  (left_forward),
    .right_forward (right_forward),
    .left_half     (left_half),
    .right_half    (right_half),
    .step_count    (step_count),
    .period        (period),
    .rd_en         (rd_en),
    .rd_idx        (rd_idx),
    .res           (res)
  );

  // result staging towards the receiver
  dsrp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_go),
    .push_data (res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign left_clk      = out_res.left_clk;
  assign right_clk     = out_res.right_clk;
  assign left_dir_pin  = out_res.left_dir_pin;
  assign right_dir_pin = out_res.right_dir_pin;
  assign enable_pin    = out_res.busy;
  assign busy_res      = out_res.busy;
  assign accepted      = out_res.accepted;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

// checks the two-motor step / direction generator item by item against a local
// model of the motor state, over several idling phases and slow factor settings

module tb_top;
  import dsrp_pkg::*;

  localparam int RAMP_LEN = RAMP_DEPTH_DEF;
  localparam int RC_W = $clog2(RAMP_LEN + 1);
  localparam logic [PERIOD_W-1:0] PERIOD_CAP = '1;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = 15'd25600;

  // one command item as the sender sees it
  typedef struct {
    cmd_t op;
    logic lfwd;
    logic rfwd;
    logic lhalf;
    logic rhalf;
    logic [STEPS_W-1:0] count;
  } motor_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // every input known from time zero
  logic cfg_we = 1'b0;
  logic [FACTOR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [1:0] cmd = CMD_TICK;
  logic left_forward = 1'b0;
  logic right_forward = 1'b0;
  logic left_half = 1'b0;
  logic right_half = 1'b0;
  logic [STEPS_W-1:0] step_count = '0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic left_clk;
  logic right_clk;
  logic left_dir_pin;
  logic right_dir_pin;
  logic enable_pin;
  logic busy_res;
  logic accepted;

  dual_stepper_ramp_pulser #(
    .RAMP_DEPTH(RAMP_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .left_forward(left_forward),
    .right_forward(right_forward),
    .left_half(left_half),
    .right_half(right_half),
    .step_count(step_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .left_clk(left_clk),
    .right_clk(right_clk),
    .left_dir_pin(left_dir_pin),
    .right_dir_pin(right_dir_pin),
    .enable_pin(enable_pin),
    .busy_res(busy_res),
    .accepted(accepted)
  );

  // items waiting to be sent, and pin levels owed by the block, oldest first
  motor_cmd_t pending_cmds[$];
  res_t pin_levels_due[$];
  motor_cmd_t shown_cmd;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;

  // local copy of the motor state
  logic [FACTOR_W-1:0] slow_factor;
  mode_t mot_mode;
  logic [RC_W-1:0] ramp_cnt;
  logic [STEPS_W-1:0] steps_rem;
  logic [STEPS_W-1:0] step_idx;
  logic [PERIOD_W-1:0] tmr;
  logic clk_high;
  logic [1:0] half_sel;
  logic [1:0] dir_lvl;
  logic [1:0] pulse_sel;

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // motor model
  // ---------------------------------------------------------------------------

  function automatic void reset_motor_model();
    slow_factor = '0;
    mot_mode = MODE_IDLE;
    ramp_cnt = '0;
    steps_rem = '0;
    step_idx = '0;
    tmr = '0;
    clk_high = 1'b0;
    half_sel = 2'b00;
    dir_lvl = DIR_IDLE;
    pulse_sel = 2'b00;
  endfunction

  // table entry stretched by the q7.8 slow factor, index past the end reads the last
  function automatic logic [PERIOD_W-1:0] ramp_period(int idx, logic [FACTOR_W-1:0] f);
    logic [31:0] e;
    logic [31:0] p;
    if (idx >= TABLE_SIZE) idx = TABLE_SIZE - 1;
    e = 32'(RAMP_TABLE[idx]);
    p = e + ((e * 32'(f)) >> FRAC_W);
    return (p > 32'(PERIOD_CAP)) ? PERIOD_CAP : p[PERIOD_W-1:0];
  endfunction

  function automatic void begin_step();
    logic odd;
    int idx;
    if (mot_mode == MODE_MOVE) begin
      // parity from the step number, counter clamped before use
      odd = step_idx[0];
      idx = (int'(ramp_cnt) < RAMP_LEN - 1) ? int'(ramp_cnt) : RAMP_LEN - 1;
      ramp_cnt = RC_W'(idx + 1);
      step_idx = step_idx + 1'b1;
      steps_rem = steps_rem - 1'b1;
    end else begin
      // decelerating: parity from the counter before it drops
      odd = ramp_cnt[0];
      ramp_cnt = ramp_cnt - 1'b1;
      idx = (int'(ramp_cnt) < RAMP_LEN - 1) ? int'(ramp_cnt) : RAMP_LEN - 1;
    end
    pulse_sel[0] = !half_sel[0] || odd;
    pulse_sel[1] = !half_sel[1] || odd;
    tmr = ramp_period(idx, slow_factor);
    clk_high = 1'b1;
  endfunction

  function automatic void enter_idle(logic restore_dirs);
    mot_mode = MODE_IDLE;
    clk_high = 1'b0;
    tmr = '0;
    if (restore_dirs) dir_lvl = DIR_IDLE;
  endfunction

  // advances the model by one item and gives the pin levels it leaves behind
  function automatic res_t predict_pins(motor_cmd_t it);
    res_t r;
    logic took;
    took = 1'b0;
    case (it.op)
      CMD_TICK: begin
        if (mot_mode != MODE_IDLE) begin
          if (clk_high) begin
            if (tmr != 0) tmr = tmr - 1'b1;
            if (tmr == 0) clk_high = 1'b0;
          end else if (mot_mode == MODE_MOVE) begin
            if (steps_rem != 0) begin_step();
            else enter_idle(1'b0);
          end else begin
            if (ramp_cnt != 0) begin_step();
            else enter_idle(1'b1);
          end
        end
      end
      CMD_MOVE: begin
        if (mot_mode == MODE_IDLE) begin
          took = 1'b1;
          dir_lvl = {~it.rfwd, it.lfwd};
          half_sel = {it.rhalf, it.lhalf};
          steps_rem = it.count;
          step_idx = '0;
          // zero-length move only latches pins and flags
          if (steps_rem != 0) begin
            mot_mode = MODE_MOVE;
            begin_step();
          end
        end
      end
      CMD_SOFT_STOP: begin
        if (mot_mode == MODE_IDLE && ramp_cnt != 0) begin
          took = 1'b1;
          mot_mode = MODE_DECEL;
          begin_step();
        end
      end
      default: begin
        if (mot_mode != MODE_IDLE || ramp_cnt != 0) begin
          took = 1'b1;
          ramp_cnt = '0;
          steps_rem = '0;
          enter_idle(1'b1);
        end
      end
    endcase
    r.left_clk = clk_high && pulse_sel[0];
    r.right_clk = clk_high && pulse_sel[1];
    r.left_dir_pin = dir_lvl[0];
    r.right_dir_pin = dir_lvl[1];
    r.busy = (mot_mode != MODE_IDLE);
    r.accepted = took;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: presents queued items, predicts each one as it is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      reset_motor_model();
    end else begin
      if (in_valid && !in_stall) pin_levels_due.push_back(predict_pins(shown_cmd));
      // a stalled item stays put; otherwise load the next one or go quiet
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          cmd <= shown_cmd.op;
          left_forward <= shown_cmd.lfwd;
          right_forward <= shown_cmd.rfwd;
          left_half <= shown_cmd.lhalf;
          right_half <= shown_cmd.rhalf;
          step_count <= shown_cmd.count;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall, every taken result checked against the oldest due
  // ---------------------------------------------------------------------------

  function automatic void check_pin(string what, logic want, logic got);
    if (want !== got) begin
      $display("%0t %s: expected %0b, got %0b", $time, what, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_mon
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pin_levels_due.size() == 0) begin
          $display("%0t result with nothing due: expected none, got %b", $time,
                   {left_clk, right_clk, left_dir_pin, right_dir_pin, enable_pin,
                    busy_res, accepted});
          err_count++;
        end else begin
          want = pin_levels_due.pop_front();
          check_pin("left_clk", want.left_clk, left_clk);
          check_pin("right_clk", want.right_clk, right_clk);
          check_pin("left_dir_pin", want.left_dir_pin, left_dir_pin);
          check_pin("right_dir_pin", want.right_dir_pin, right_dir_pin);
          check_pin("enable_pin", want.busy, enable_pin);
          check_pin("busy_res", want.busy, busy_res);
          check_pin("accepted", want.accepted, accepted);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_cmd(cmd_t op, logic lf, logic rf, logic lh, logic rh,
                                   logic [STEPS_W-1:0] n);
    motor_cmd_t it;
    it.op = op;
    it.lfwd = lf;
    it.rfwd = rf;
    it.lhalf = lh;
    it.rhalf = rh;
    it.count = n;
    pending_cmds.push_back(it);
  endfunction

  function automatic void push_op(cmd_t op);
    push_cmd(op, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
             STEPS_W'($urandom));
  endfunction

  // step counts lean small, with zero, the top value and the full range mixed in
  function automatic logic [STEPS_W-1:0] rand_count();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick < 6) return STEPS_W'($urandom_range(1, 8));
    return STEPS_W'($urandom_range(0, 65535));
  endfunction

  function automatic void push_move(logic lh, logic rh, logic [STEPS_W-1:0] n);
    push_cmd(CMD_MOVE, 1'($urandom), 1'($urandom), lh, rh, n);
  endfunction

  // short well-formed sequences with random content, plus noise
  function automatic void queue_random(int n);
    int made;
    int pick;
    int burst;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_move(1'($urandom), 1'($urandom), rand_count());
        burst = $urandom_range(12);
        for (int i = 0; i < burst; i++) begin
          if ($urandom_range(9) == 0) push_op($urandom_range(1) ? CMD_MOVE : CMD_SOFT_STOP);
          else push_op(CMD_TICK);
        end
        made += burst + 1;
        if ($urandom_range(9) < 7) begin
          push_op(CMD_FORCE_STOP);
          made++;
        end
      end else if (pick < 70) begin
        burst = $urandom_range(1, 20);
        repeat (burst) push_op(CMD_TICK);
        made += burst;
      end else if (pick < 80) begin
        push_op(CMD_SOFT_STOP);
        made++;
      end else if (pick < 90) begin
        push_op(CMD_FORCE_STOP);
        made++;
      end else begin
        push_op(cmd_t'($urandom_range(3)));
        made++;
      end
    end
  endfunction

  // waits until every queued item is taken and every result has come back
  task automatic drain_all();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || pin_levels_due.size() != 0);
  endtask

  // slow factor written only with the motor stopped and the pipeline empty
  task automatic write_factor(logic [FACTOR_W-1:0] v);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slow_factor = v;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // phase 0: no idling, slow factor at its reset value of zero
    send_idle_pct = 0;
    stall_pct = 0;

    // idle corner cases: nothing to stop, nothing to decelerate
    push_op(CMD_TICK);
    push_op(CMD_SOFT_STOP);
    push_op(CMD_FORCE_STOP);
    // zero-length move only latches dir pins and half flags
    push_cmd(CMD_MOVE, 1'b0, 1'b0, 1'b1, 1'b1, '0);
    push_op(CMD_TICK);
    // longest move, then the commands a busy motor ignores
    push_cmd(CMD_MOVE, 1'b1, 1'b1, 1'b0, 1'b0, '1);
    push_cmd(CMD_MOVE, 1'b0, 1'b0, 1'b1, 1'b1, 16'd5);
    push_op(CMD_SOFT_STOP);
    repeat (3) push_op(CMD_TICK);
    push_op(CMD_FORCE_STOP);
    push_op(CMD_FORCE_STOP);
    // half rate: step zero is even, so the half side stays low
    push_cmd(CMD_MOVE, 1'b0, 1'b0, 1'b1, 1'b0, 16'd1);
    push_op(CMD_TICK);
    push_op(CMD_FORCE_STOP);
    push_cmd(CMD_MOVE, 1'b1, 1'b0, 1'b0, 1'b1, 16'd2);
    push_op(CMD_FORCE_STOP);

    queue_random(300);
    push_op(CMD_FORCE_STOP);
    drain_all();

    // phase 1: sender mostly idle, largest slow factor
    write_factor(FACTOR_MAX);
    send_idle_pct = 85;
    stall_pct = 0;
    queue_random(300);
    push_op(CMD_FORCE_STOP);
    drain_all();

    // phase 2: receiver mostly stalling, zero factor written back
    write_factor('0);
    send_idle_pct = 0;
    stall_pct = 85;
    push_op(CMD_FORCE_STOP);
    queue_random(300);
    push_op(CMD_FORCE_STOP);
    drain_all();

    // phase 3: both sides idling, small random factor with a fractional part
    write_factor(FACTOR_W'($urandom_range(1, 64)));
    send_idle_pct = 30;
    stall_pct = 30;
    queue_random(150);
    // sender holds off until the block has answered everything
    drain_all();
    queue_random(150);
    push_op(CMD_FORCE_STOP);
    drain_all();

    // a few quiet cycles to catch any stray result
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("[dual_stepper_ramp_pulser] OK");
    end else begin
      $display("[dual_stepper_ramp_pulser] ERROR");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("[dual_stepper_ramp_pulser] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dsrp_pkg.sv
sv/dsrp_period.sv
sv/dsrp_ctrl.sv
sv/dsrp_skid.sv
sv/dual_stepper_ramp_pulser.sv
test/tb_top.sv
